/* src/rrtt_pkg.sv */
// Shared types and constants for the round-robin thread table.
`default_nettype none

package rrtt_pkg;

  // Default number of thread slots
  localparam int unsigned DEF_THREAD_SLOTS = 16;

  // Fixed field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TID_W   = 16;
  localparam int unsigned PID_W   = 32;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned PRIO_W  = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CTX_W   = PID_W + ADDR_W + ADDR_W + PRIO_W;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    OP_CREATE    = 2'd0,
    OP_TERMINATE = 2'd1,
    OP_FREEZE    = 2'd2,
    OP_YIELD     = 2'd3
  } op_t;

  // Slot status codes
  typedef enum logic [STAT_W-1:0] {
    ST_UNUSED     = 3'd0,
    ST_READY      = 3'd1,
    ST_RUNNING    = 3'd2,
    ST_FROZEN     = 3'd3,
    ST_TERMINATED = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

`default_nettype wire

/* src/rrtt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* src/rrtt_pick.sv */
// Slot pickers: lowest free slot for create, round-robin dispatch for yield.
`default_nettype none

module rrtt_pick #(
  parameter int unsigned THREAD_SLOTS = rrtt_pkg::DEF_THREAD_SLOTS,
  localparam int unsigned SW = $clog2(THREAD_SLOTS)
) (
  input  wire logic [THREAD_SLOTS-1:0] free_mask,
  input  wire logic [THREAD_SLOTS-1:0] disp_mask,
  input  wire logic [SW-1:0]           cur_slot,
  output logic                         free_found,
  output logic      [SW-1:0]           free_slot,
  output logic                         disp_found,
  output logic      [SW-1:0]           disp_slot
);

  logic [THREAD_SLOTS-1:0] above_mask;
  logic [THREAD_SLOTS-1:0] disp_above;
  logic                    above_found;
  logic [SW-1:0]           above_slot;
  logic                    any_found;
  logic [SW-1:0]           any_slot;

  // Lowest set bit of a slot vector
  function automatic logic [SW:0] lowest(input logic [THREAD_SLOTS-1:0] vec);
    logic [SW:0] res;
    res = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res = {1'b1, SW'(i)};
      end
    end
    return res;
  endfunction

  // Mark slots strictly after the current one
  always_comb begin
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      above_mask[i] = (SW'(i) > cur_slot);
    end
  end

  assign disp_above = disp_mask & above_mask;

  assign {free_found, free_slot}   = lowest(free_mask);
  assign {above_found, above_slot} = lowest(disp_above);
  assign {any_found, any_slot}     = lowest(disp_mask);

  // Prefer a slot after the current one, else wrap to the lowest
  assign disp_found = any_found;
  assign disp_slot  = above_found ? above_slot : any_slot;

endmodule

`default_nettype wire

/* src/round_robin_thread_table.sv */
// Top level of the round-robin thread table.
//
// Usage: present an operation on the in_ ports with start high; it is
// taken at a rising edge where start is high and busy is low. Operations
// are create, terminate, freeze and yield (in_kind). Each transfer produces
// exactly one result: out_valid is high for one cycle, carrying out_success
// and out_result_id (new or dispatched id, slot plus one, else zero).
// The result appears in the cycle after the transfer. No new operation is
// taken while one executes: the slot status RAM read is registered at
// the transfer and followed by the read-modify-write in the execute
// state, where busy is high. Round-robin and free-slot selection come from
// per-slot free and dispatchable flags held in flops beside the RAM.
// Thread context (process id, entry, stack, priority) is written to its
// own RAM on create. The receiver cannot stall; results are not held.
// Reset (synchronous, rst_n low) marks all slots unused through per-slot
// valid bits, clears the active count and the current slot; the block is
// ready in the first cycle after reset with no clearing pass.
`default_nettype none

module round_robin_thread_table #(
  parameter int unsigned THREAD_SLOTS = rrtt_pkg::DEF_THREAD_SLOTS,
  localparam int unsigned SW = $clog2(THREAD_SLOTS),
  localparam int unsigned RW = $clog2(THREAD_SLOTS + 1),
  localparam int unsigned CW = $clog2(THREAD_SLOTS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rrtt_pkg::KIND_W-1:0] in_kind,
  input  wire logic [rrtt_pkg::TID_W-1:0]  in_thread_id,
  input  wire logic [rrtt_pkg::PID_W-1:0]  in_process_id,
  input  wire logic [rrtt_pkg::ADDR_W-1:0] in_entry_address,
  input  wire logic [rrtt_pkg::ADDR_W-1:0] in_stack_address,
  input  wire logic [rrtt_pkg::PRIO_W-1:0] in_priority_req,
  output logic                             out_valid,
  output logic                             out_success,
  output logic      [RW-1:0]               out_result_id
);

  rrtt_pkg::state_t state_r, state_nxt;

  // Command registers
  rrtt_pkg::op_t               kind_r;
  logic                        id_ok_r;
  logic [SW-1:0]               tslot_r;
  logic [rrtt_pkg::CTX_W-1:0]  ctx_r;

  // Control state
  logic [THREAD_SLOTS-1:0] free_r, free_nxt;
  logic [THREAD_SLOTS-1:0] disp_r, disp_nxt;
  logic [THREAD_SLOTS-1:0] sval_r, sval_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [SW-1:0]           cur_r, cur_nxt;

  // Accept and address decode
  logic                         accept;
  logic                         in_id_ok;
  logic [rrtt_pkg::TID_W-1:0]   in_id_m1;
  logic [SW-1:0]                in_slot;

  // Status RAM ports
  logic                         st_we;
  logic [SW-1:0]                st_waddr;
  rrtt_pkg::status_t            st_wdata;
  logic [rrtt_pkg::STAT_W-1:0]  st_rdata;
  rrtt_pkg::status_t            cur_st;

  // Picker outputs
  logic          free_found;
  logic [SW-1:0] free_slot;
  logic          disp_found;
  logic [SW-1:0] disp_slot;

  // Result
  logic          ok;
  logic [RW-1:0] rid;
  logic          ctx_we;

  assign accept   = start && !busy;
  assign in_id_ok = (in_thread_id != '0) &&
                    (in_thread_id <= rrtt_pkg::TID_W'(THREAD_SLOTS));
  assign in_id_m1 = in_thread_id - rrtt_pkg::TID_W'(1);
  assign in_slot  = in_id_m1[SW-1:0];

  // Status store: one entry per slot, read at transfer, written back next cycle
  rrtt_ram #(
    .WIDTH (rrtt_pkg::STAT_W),
    .DEPTH (THREAD_SLOTS)
  ) u_status_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (in_slot),
    .rd_data (st_rdata)
  );

  // Thread context store, written on create
  rrtt_ram #(
    .WIDTH (rrtt_pkg::CTX_W),
    .DEPTH (THREAD_SLOTS)
  ) u_ctx_ram (
    .clk     (clk),
    .wr_en   (ctx_we),
    .wr_addr (free_slot),
    .wr_data (ctx_r),
    .rd_addr (free_slot),
    .rd_data ()
  );

  rrtt_pick #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_pick (
    .free_mask  (free_r),
    .disp_mask  (disp_r),
    .cur_slot   (cur_r),
    .free_found (free_found),
    .free_slot  (free_slot),
    .disp_found (disp_found),
    .disp_slot  (disp_slot)
  );

  // Slots never written read as unused
  assign cur_st = sval_r[tslot_r] ? rrtt_pkg::status_t'(st_rdata) : rrtt_pkg::ST_UNUSED;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrtt_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = rrtt_pkg::S_EXEC;
        end
      end
      rrtt_pkg::S_EXEC: state_nxt = rrtt_pkg::S_IDLE;
      default:          state_nxt = rrtt_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      rrtt_pkg::S_IDLE: begin
        busy      = 1'b0;
        out_valid = 1'b0;
      end
      rrtt_pkg::S_EXEC: begin
        busy      = 1'b1;
        out_valid = 1'b1;
      end
      default: begin
        busy      = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  // Execute: decide the write-back and the result
  always_comb begin
    st_we     = 1'b0;
    st_waddr  = tslot_r;
    st_wdata  = rrtt_pkg::ST_UNUSED;
    ctx_we    = 1'b0;
    ok        = 1'b0;
    rid       = '0;
    free_nxt  = free_r;
    disp_nxt  = disp_r;
    sval_nxt  = sval_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    if (state_r == rrtt_pkg::S_EXEC) begin
      case (kind_r)
        rrtt_pkg::OP_CREATE: begin
          if (free_found) begin
            st_we               = 1'b1;
            st_waddr            = free_slot;
            st_wdata            = rrtt_pkg::ST_READY;
            ctx_we              = 1'b1;
            ok                  = 1'b1;
            rid                 = RW'(free_slot) + RW'(1);
            free_nxt[free_slot] = 1'b0;
            disp_nxt[free_slot] = 1'b1;
            sval_nxt[free_slot] = 1'b1;
            count_nxt           = count_r + CW'(1);
          end
        end
        rrtt_pkg::OP_TERMINATE: begin
          if (id_ok_r && cur_st != rrtt_pkg::ST_UNUSED) begin
            st_we             = 1'b1;
            st_wdata          = rrtt_pkg::ST_TERMINATED;
            ok                = 1'b1;
            free_nxt[tslot_r] = 1'b1;
            disp_nxt[tslot_r] = 1'b0;
            sval_nxt[tslot_r] = 1'b1;
            if (count_r != '0) begin
              count_nxt = count_r - CW'(1);
            end
          end
        end
        rrtt_pkg::OP_FREEZE: begin
          if (id_ok_r && cur_st == rrtt_pkg::ST_RUNNING) begin
            st_we             = 1'b1;
            st_wdata          = rrtt_pkg::ST_FROZEN;
            ok                = 1'b1;
            disp_nxt[tslot_r] = 1'b0;
            sval_nxt[tslot_r] = 1'b1;
          end
        end
        rrtt_pkg::OP_YIELD: begin
          if (count_r != '0 && disp_found) begin
            st_we               = 1'b1;
            st_waddr            = disp_slot;
            st_wdata            = rrtt_pkg::ST_RUNNING;
            ok                  = 1'b1;
            rid                 = RW'(disp_slot) + RW'(1);
            sval_nxt[disp_slot] = 1'b1;
            cur_nxt             = disp_slot;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  assign out_success   = ok;
  assign out_result_id = rid;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrtt_pkg::S_IDLE;
      free_r  <= '1;
      disp_r  <= '0;
      sval_r  <= '0;
      count_r <= '0;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      disp_r  <= disp_nxt;
      sval_r  <= sval_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
    end
  end

  // Capture the command on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= rrtt_pkg::op_t'(in_kind);
      id_ok_r <= in_id_ok;
      tslot_r <= in_slot;
      ctx_r   <= {in_process_id, in_entry_address, in_stack_address, in_priority_req};
    end
  end

  // Every transfer yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("missing result after transfer");

  // No result without a transfer in the cycle before
  a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result without a transfer");

  // A free slot is never dispatchable
  a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r & disp_r) == '0)
    else $error("slot both free and dispatchable");

  // Active count never exceeds the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(THREAD_SLOTS))
    else $error("active count out of range");

  // Successful yield makes the dispatched slot current
  a_yield_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_success && kind_r == rrtt_pkg::OP_YIELD |=>
      RW'(cur_r) + RW'(1) == $past(out_result_id))
    else $error("dispatched slot not made current");

endmodule

`default_nettype wire
